/* design/dfrq_pkg.sv */
`timescale 1ns / 1ps
package dfrq_pkg;

  localparam int DEFAULT_QUEUE_SLOTS = 8;
  localparam int DEFAULT_IDLE_BITS   = 16;

  // Longest body a slot can hold, and the body address bits inside a slot.
  localparam int MAX_BODY = 62;
  localparam int BODY_AW  = 6;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [7:0]  DELIM_RST   = 8'd0;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [5:0]  MAXLEN_RST  = 6'd62;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_POP  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_TAKEN      = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_FULL       = 3'd2,
    ST_BAD_START  = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_FRAME_BYTE = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM   = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_MAXLEN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] queue_level;
    logic       resynced;
  } out_rsp_t;

  typedef struct packed {
    logic byte_go;
    logic tick_go;
    logic pop_go;
    logic stream_go;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic stream_last;
  } dp_status_t;

endpackage

/* design/delimited_frame_receiver_queue_top.sv */
`timescale 1ns / 1ps
// A byte request or an empty pop gives its result in the cycle after acceptance.
// Throughput: one byte or tick request per cycle while the result register drains.
// A pop streams 2 + length frame bytes, one per unstalled cycle, the first in the
// cycle after acceptance; new requests wait until the last frame byte is taken.
// Reset (asynchronous, active low) clears the parser, ring pointers and registers.
module delimited_frame_receiver_queue_top #(
  parameter int QUEUE_SLOTS = dfrq_pkg::DEFAULT_QUEUE_SLOTS,
  parameter int IDLE_BITS   = dfrq_pkg::DEFAULT_IDLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dfrq_pkg::in_req_t              in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dfrq_pkg::out_rsp_t             out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [dfrq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dfrq_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import dfrq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  dfrq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (in_req_i.kind),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  dfrq_dp #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .IDLE_BITS   (IDLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .rx_byte_i   (in_req_i.rx_byte),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_rsp_o)
  );

endmodule

/* design/dfrq_ram.sv */
`timescale 1ns / 1ps
module dfrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dfrq_ctrl.sv */
`timescale 1ns / 1ps
module dfrq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            kind_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  dfrq_pkg::dp_status_t  status_i,
  output dfrq_pkg::ctl_cmd_t    cmd_o
);
  import dfrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  ctl_cmd_t   cmd;

  always_comb begin
    cmd        = '0;
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_free   = !out_valid_q || !out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          unique case (kind_e'(kind_i))
            KIND_BYTE: cmd.byte_go = 1'b1;
            KIND_TICK: cmd.tick_go = 1'b1;
            KIND_POP: begin
              cmd.pop_go = 1'b1;
              if (!status_i.empty) begin
                state_d = S_POP;
              end
            end
            KIND_NONE: cmd = '0;
          endcase
        end
      end
      S_POP: begin
        // The output register takes one frame byte per free cycle.
        if (out_free) begin
          cmd.stream_go = 1'b1;
          if (status_i.stream_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd.byte_go || cmd.pop_go || cmd.stream_go ||
                  (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* design/dfrq_dp.sv */
`timescale 1ns / 1ps
module dfrq_dp #(
  parameter int QUEUE_SLOTS = dfrq_pkg::DEFAULT_QUEUE_SLOTS,
  parameter int IDLE_BITS   = dfrq_pkg::DEFAULT_IDLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dfrq_pkg::ctl_cmd_t            cmd_i,
  output dfrq_pkg::dp_status_t          status_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [dfrq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dfrq_pkg::CFG_W-1:0]    cfg_wdata_i,
  output dfrq_pkg::out_rsp_t            rsp_o
);
  import dfrq_pkg::*;

  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int MEM_DEPTH = QUEUE_SLOTS << BODY_AW;
  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int CMP_W = (IDLE_BITS > 16) ? IDLE_BITS : 16;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  function automatic logic [2:0] ring_level(input logic [SLOT_W-1:0] w,
                                            input logic [SLOT_W-1:0] r);
    logic [SLOT_W:0] lv;
    logic [4:0]      wide;
    if (w >= r) begin
      lv = {1'b0, w} - {1'b0, r};
    end else begin
      lv = {1'b0, w} + (SLOT_W+1)'(QUEUE_SLOTS) - {1'b0, r};
    end
    wide = 5'(lv);
    return wide[2:0];
  endfunction

  // Configuration
  logic [7:0]  delim_q;
  logic [15:0] timeout_q;
  logic [5:0]  maxlen_q;

  // Parser and ring state
  phase_e               phase_q, phase_d, phase_eff;
  logic [5:0]           pos_q, pos_d, pos_eff;
  logic [5:0]           rem_q, rem_d, rem_eff, rem_m1;
  logic [IDLE_BITS-1:0] idle_q, idle_d;
  logic [SLOT_W-1:0]    w_q, w_d, r_q, r_d, w_inc, r_inc;
  logic [7:0]           hdr_type_q, hdr_type_d, hdr_len_q, hdr_len_d;
  logic [7:0]           slot_type_q [QUEUE_SLOTS];
  logic [7:0]           slot_len_q  [QUEUE_SLOTS];
  logic                 slot_we;

  // Pop streaming
  logic [SLOT_W-1:0] pop_slot_q, pop_slot_d;
  logic [5:0]        pop_len_q, pop_len_d;
  logic [7:0]        pop_type_q, pop_type_d;
  logic [5:0]        out_idx_q, out_idx_d;
  logic [7:0]        slot_len_rd;
  logic              stream_last;

  logic [CMP_W-1:0] idle_ext, timeout_ext;
  logic             resync, commit, mem_we;
  logic [5:0]       limit;
  status_e          byte_st;
  logic [7:0]       mem_rdata, stream_byte;
  out_rsp_t         rsp_q, rsp_d;

  assign w_inc = (w_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : w_q + 1'b1;
  assign r_inc = (r_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : r_q + 1'b1;

  assign idle_ext    = CMP_W'(idle_q);
  assign timeout_ext = CMP_W'(timeout_q);
  assign resync      = idle_ext > timeout_ext;
  assign limit       = (maxlen_q < 6'(MAX_BODY)) ? maxlen_q : 6'(MAX_BODY);

  assign phase_eff = resync ? PH_HUNT : phase_q;
  assign pos_eff   = resync ? 6'd0 : pos_q;
  assign rem_eff   = resync ? 6'd0 : rem_q;
  assign rem_m1    = rem_eff - 6'd1;

  assign slot_len_rd = slot_len_q[r_q];
  assign stream_last = out_idx_q == (pop_len_q + 6'd1);
  assign stream_byte = (out_idx_q == 6'd1) ? {2'b00, pop_len_q} : mem_rdata;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    idle_d     = idle_q;
    w_d        = w_q;
    r_d        = r_q;
    hdr_type_d = hdr_type_q;
    hdr_len_d  = hdr_len_q;
    commit     = 1'b0;
    slot_we    = 1'b0;
    mem_we     = 1'b0;
    byte_st    = ST_TAKEN;
    pop_slot_d = pop_slot_q;
    pop_len_d  = pop_len_q;
    pop_type_d = pop_type_q;
    out_idx_d  = out_idx_q;
    rsp_d      = rsp_q;

    if (cmd_i.tick_go && (idle_q != '1)) begin
      idle_d = idle_q + 1'b1;
    end

    if (cmd_i.byte_go) begin
      idle_d  = '0;
      phase_d = phase_eff;
      pos_d   = pos_eff;
      rem_d   = rem_eff;
      unique case (phase_eff)
        PH_HEAD: begin
          if (pos_eff == 6'd0) begin
            hdr_type_d = rx_byte_i;
            pos_d      = 6'd1;
          end else begin
            hdr_len_d = rx_byte_i;
            pos_d     = 6'd0;
            if (rx_byte_i == 8'd0) begin
              commit  = 1'b1;
              phase_d = PH_HUNT;
            end else if (rx_byte_i <= {2'b00, limit}) begin
              rem_d   = rx_byte_i[5:0];
              phase_d = PH_BODY;
            end else begin
              byte_st = ST_TOO_LONG;
              phase_d = PH_HUNT;
            end
          end
        end
        PH_BODY: begin
          mem_we = 1'b1;
          pos_d  = pos_eff + 6'd1;
          rem_d  = rem_m1;
          if (rem_m1 == 6'd0) begin
            commit  = 1'b1;
            phase_d = PH_HUNT;
            pos_d   = 6'd0;
          end
        end
        PH_HUNT: begin
          if (rx_byte_i == delim_q) begin
            phase_d = PH_HEAD;
            pos_d   = 6'd0;
          end else begin
            byte_st = ST_BAD_START;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
      if (commit) begin
        // One slot always stays free so that a full ring differs from an empty one.
        if (w_inc == r_q) begin
          byte_st = ST_FULL;
        end else begin
          byte_st = ST_QUEUED;
          slot_we = 1'b1;
          w_d     = w_inc;
        end
      end
      rsp_d = '{status: byte_st, out_byte: 8'd0, last: 1'b0,
                queue_level: ring_level(w_d, r_q), resynced: resync};
    end else if (cmd_i.pop_go) begin
      if (w_q == r_q) begin
        rsp_d = '{status: ST_EMPTY, out_byte: 8'd0, last: 1'b0,
                  queue_level: ring_level(w_q, r_q), resynced: 1'b0};
      end else begin
        pop_slot_d = r_q;
        pop_type_d = slot_type_q[r_q];
        pop_len_d  = (slot_len_rd > 8'(MAX_BODY)) ? 6'(MAX_BODY) : slot_len_rd[5:0];
        r_d        = r_inc;
        out_idx_d  = 6'd1;
        rsp_d = '{status: ST_FRAME_BYTE, out_byte: pop_type_d, last: 1'b0,
                  queue_level: ring_level(w_q, r_inc), resynced: 1'b0};
      end
    end else if (cmd_i.stream_go) begin
      out_idx_d = out_idx_q + 6'd1;
      rsp_d = '{status: ST_FRAME_BYTE, out_byte: stream_byte, last: stream_last,
                queue_level: ring_level(w_q, r_q), resynced: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= DELIM_RST;
      timeout_q  <= TIMEOUT_RST;
      maxlen_q   <= MAXLEN_RST;
      phase_q    <= PH_HUNT;
      pos_q      <= '0;
      rem_q      <= '0;
      idle_q     <= '0;
      w_q        <= '0;
      r_q        <= '0;
      pop_slot_q <= '0;
      out_idx_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_DELIM:   delim_q   <= cfg_wdata_i[7:0];
          CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
          CFG_MAXLEN:  maxlen_q  <= cfg_wdata_i[5:0];
          default:     delim_q   <= delim_q;
        endcase
      end
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      idle_q     <= idle_d;
      w_q        <= w_d;
      r_q        <= r_d;
      pop_slot_q <= pop_slot_d;
      out_idx_q  <= out_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_type_q <= hdr_type_d;
    hdr_len_q  <= hdr_len_d;
    pop_len_q  <= pop_len_d;
    pop_type_q <= pop_type_d;
    rsp_q      <= rsp_d;
    if (slot_we) begin
      slot_type_q[w_q] <= hdr_type_q;
      slot_len_q[w_q]  <= hdr_len_d;
    end
  end

  // The read address follows the next stream index, so the registered read
  // data always belongs to the byte that the stream index points at.
  dfrq_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (MEM_AW'({w_q, pos_eff})),
    .wdata_i (rx_byte_i),
    .raddr_i (MEM_AW'({pop_slot_d, out_idx_d - 6'd2})),
    .rdata_o (mem_rdata)
  );

  assign status_o.empty       = (w_q == r_q);
  assign status_o.stream_last = stream_last;
  assign rsp_o                = rsp_q;

endmodule

/* design/dfrq_checker.sv */
`timescale 1ns / 1ps
module dfrq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input dfrq_pkg::in_req_t              in_req_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input dfrq_pkg::out_rsp_t             out_rsp_o,
  input logic                           cfg_we_i,
  input logic [dfrq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [dfrq_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import dfrq_pkg::*;

  // Only popped frame bytes carry data and the end marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_FRAME_BYTE) |->
      (out_rsp_o.out_byte == 8'd0) && !out_rsp_o.last)
    else $error("non-frame result carries byte data");

  // A resync flag can only come with the result of a received byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.resynced |->
      (out_rsp_o.status != ST_EMPTY) && (out_rsp_o.status != ST_FRAME_BYTE))
    else $error("resync flag on a pop result");

  // An empty pop means the ring holds no frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_EMPTY) |-> (out_rsp_o.queue_level == 3'd0))
    else $error("empty pop with frames queued");

  // A held result stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

endmodule

bind delimited_frame_receiver_queue_top dfrq_checker u_dfrq_checker (.*);

/* sim/delimited_frame_receiver_queue_top_test.sv */
`timescale 1ns / 1ps
module delimited_frame_receiver_queue_top_test;
  import dfrq_pkg::*;

  localparam int SLOTS        = DEFAULT_QUEUE_SLOTS;
  localparam int IDLE_W       = DEFAULT_IDLE_BITS;
  localparam int HEADER_BYTES = 2;
  localparam int SLOT_BYTES   = HEADER_BYTES + MAX_BODY;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int ROWS         = 23;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } parse_phase_e;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    bit         fixed;
    out_rsp_t   rsp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Fixed expectation that travels alongside the request it belongs to.
  bit req_fixed = 1'b0;
  out_rsp_t req_fixed_rsp = '0;

  // Predictor state and its copy of the registers.
  logic [7:0]        delim_cfg   = DELIM_RST;
  logic [15:0]       timeout_cfg = TIMEOUT_RST;
  logic [5:0]        maxlen_cfg  = MAXLEN_RST;
  parse_phase_e      parse_phase = PH_HUNT;
  logic [7:0]        hdr [HEADER_BYTES];
  logic [5:0]        body_left   = '0;
  logic [5:0]        body_pos    = '0;
  logic [IDLE_W-1:0] idle_ticks  = '0;
  logic [7:0]        ring [SLOTS][SLOT_BYTES];
  int                wr_slot     = 0;
  int                rd_slot     = 0;

  out_rsp_t pending_rsp [$];
  out_rsp_t want;
  int mismatches = 0;
  int cycles = 0;
  int sent_items = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  stim_row_t directed [ROWS];

  delimited_frame_receiver_queue_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [2:0] ring_level();
    return 3'((wr_slot + SLOTS - rd_slot) % SLOTS);
  endfunction

  function automatic status_e commit_frame();
    int nxt;
    nxt = (wr_slot + 1) % SLOTS;
    if (nxt == rd_slot) return ST_FULL;
    ring[wr_slot][0] = hdr[0];
    ring[wr_slot][1] = hdr[1];
    wr_slot = nxt;
    return ST_QUEUED;
  endfunction

  function automatic out_rsp_t plain_rsp(status_e st, logic [2:0] lvl);
    return out_rsp_t'{st, 8'h00, 1'b0, lvl, 1'b0};
  endfunction

  task automatic predict_rsp(in_req_t req);
    status_e st;
    logic resync;
    int len;
    int lim;
    int slot;
    case (req.kind)
      KIND_BYTE: begin
        resync = 1'b0;
        if (idle_ticks > timeout_cfg) begin
          parse_phase = PH_HUNT;
          body_pos = '0;
          body_left = '0;
          resync = 1'b1;
        end
        idle_ticks = '0;
        st = ST_TAKEN;
        case (parse_phase)
          PH_HEADER: begin
            hdr[body_pos[0]] = req.rx_byte;
            body_pos++;
            if (body_pos >= HEADER_BYTES) begin
              len = hdr[1];
              lim = (maxlen_cfg < MAX_BODY) ? maxlen_cfg : MAX_BODY;
              body_pos = '0;
              if (len == 0) begin
                st = commit_frame();
                parse_phase = PH_HUNT;
              end else if (len <= lim) begin
                body_left = 6'(len);
                parse_phase = PH_BODY;
              end else begin
                st = ST_TOO_LONG;
                parse_phase = PH_HUNT;
              end
            end
          end
          PH_BODY: begin
            // Body bytes land in the write slot before the frame is committed.
            ring[wr_slot][HEADER_BYTES + body_pos] = req.rx_byte;
            body_pos++;
            body_left--;
            if (body_left == 0) begin
              st = commit_frame();
              parse_phase = PH_HUNT;
              body_pos = '0;
            end
          end
          default: begin
            if (req.rx_byte == delim_cfg) begin
              parse_phase = PH_HEADER;
              body_pos = '0;
            end else begin
              st = ST_BAD_START;
            end
          end
        endcase
        pending_rsp.push_back(out_rsp_t'{st, 8'h00, 1'b0, ring_level(), resync});
      end
      KIND_TICK: begin
        if (idle_ticks != '1) idle_ticks++;
      end
      KIND_POP: begin
        if (rd_slot == wr_slot) begin
          pending_rsp.push_back(plain_rsp(ST_EMPTY, ring_level()));
        end else begin
          slot = rd_slot;
          len = ring[slot][1];
          if (len > MAX_BODY) len = MAX_BODY;
          rd_slot = (rd_slot + 1) % SLOTS;
          for (int i = 0; i < HEADER_BYTES + len; i++) begin
            pending_rsp.push_back(out_rsp_t'{ST_FRAME_BYTE, ring[slot][i],
                                             i == HEADER_BYTES + len - 1, ring_level(), 1'b0});
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("delimited_frame_receiver_queue_top_test: FAIL");
      $finish;
    end
  end

  // Results are checked before the request of the same edge is predicted; no
  // request can produce a result at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_rsp.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d byte %02h last %0d level %0d resync %0d",
                     out_rsp.status, out_rsp.out_byte, out_rsp.last, out_rsp.queue_level,
                     out_rsp.resynced);
          mismatches++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp.status !== want.status || out_rsp.out_byte !== want.out_byte ||
              out_rsp.last !== want.last || out_rsp.queue_level !== want.queue_level ||
              out_rsp.resynced !== want.resynced) begin
            if (mismatches < 10) begin
              $display("mismatch: expected status %0d byte %02h last %0d level %0d resync %0d",
                       want.status, want.out_byte, want.last, want.queue_level, want.resynced);
              $display("          got      status %0d byte %02h last %0d level %0d resync %0d",
                       out_rsp.status, out_rsp.out_byte, out_rsp.last, out_rsp.queue_level,
                       out_rsp.resynced);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_rsp(in_req);
        if (req_fixed) begin
          void'(pending_rsp.pop_back());
          pending_rsp.push_back(req_fixed_rsp);
        end
      end
    end
  end

  task automatic send_req(kind_e k, logic [7:0] b, bit fixed = 1'b0, out_rsp_t fx = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= '{kind: k, rx_byte: b};
    req_fixed <= fixed;
    req_fixed_rsp <= fx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_req(KIND_TICK, 8'($urandom));
  endtask

  // Occasional idle time inside a frame, which trips the timeout when it is short.
  task automatic maybe_ticks();
    if ($urandom_range(99) < 6) send_ticks($urandom_range(1, 5));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] d, logic [15:0] t, logic [5:0] m);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DELIM;
    cfg_wdata <= {8'($urandom), d};
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_index <= CFG_MAXLEN;
    cfg_wdata <= {10'($urandom), m};
    @(posedge clk);
    cfg_we <= 1'b0;
    delim_cfg = d;
    timeout_cfg = t;
    maxlen_cfg = m;
  endtask

  task automatic run_random(int n);
    int stop;
    int r;
    int len;
    int lim;
    int nbody;
    stop = sent_items + n;
    while (sent_items < stop) begin
      r = $urandom_range(99);
      lim = (maxlen_cfg < MAX_BODY) ? maxlen_cfg : MAX_BODY;
      if (r < 55) begin
        send_req(KIND_BYTE, delim_cfg);
        maybe_ticks();
        send_req(KIND_BYTE, 8'($urandom));
        maybe_ticks();
        r = $urandom_range(99);
        if (r < 60) len = $urandom_range(0, (lim < 8) ? lim : 8);
        else if (r < 80) len = $urandom_range(0, lim);
        else if (r < 88) len = lim;
        else len = $urandom_range(lim + 1, 255);
        send_req(KIND_BYTE, 8'(len));
        if (len > 0 && len <= lim) begin
          // A few frames are cut short so that the next delimiter lands in the body.
          nbody = ($urandom_range(99) < 8) ? $urandom_range(0, len - 1) : len;
          repeat (nbody) begin
            maybe_ticks();
            send_req(KIND_BYTE, 8'($urandom));
          end
        end
      end else if (r < 80) begin
        send_req(KIND_POP, 8'($urandom));
      end else if (r < 88) begin
        send_ticks($urandom_range(1, 6));
      end else if (r < 96) begin
        send_req(KIND_BYTE, 8'($urandom));
      end else begin
        send_req(KIND_NONE, 8'($urandom));
      end
    end
  endtask

  initial begin
    directed = '{
      '{KIND_POP,  8'h00, 1'b1, plain_rsp(ST_EMPTY, 3'd0)},
      '{KIND_BYTE, 8'hFF, 1'b1, plain_rsp(ST_BAD_START, 3'd0)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_BYTE, 8'hFF, 1'b1, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_QUEUED, 3'd1)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_TAKEN, 3'd1)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_TAKEN, 3'd1)},
      '{KIND_BYTE, 8'h3F, 1'b1, plain_rsp(ST_TOO_LONG, 3'd1)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_TAKEN, 3'd1)},
      '{KIND_BYTE, 8'h5A, 1'b1, plain_rsp(ST_TAKEN, 3'd1)},
      '{KIND_BYTE, 8'h02, 1'b1, plain_rsp(ST_TAKEN, 3'd1)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_TAKEN, 3'd1)},
      '{KIND_BYTE, 8'hFF, 1'b1, plain_rsp(ST_QUEUED, 3'd2)},
      '{KIND_TICK, 8'hFF, 1'b0, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_NONE, 8'hFF, 1'b0, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_TICK, 8'h00, 1'b0, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_BYTE, 8'h01, 1'b1, plain_rsp(ST_BAD_START, 3'd2)},
      '{KIND_POP,  8'h00, 1'b0, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_POP,  8'hFF, 1'b0, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_POP,  8'h00, 1'b1, plain_rsp(ST_EMPTY, 3'd0)},
      '{KIND_BYTE, 8'h00, 1'b1, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_BYTE, 8'h80, 1'b1, plain_rsp(ST_TAKEN, 3'd0)},
      '{KIND_BYTE, 8'h3E, 1'b1, plain_rsp(ST_TAKEN, 3'd0)}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 21;
    rx_idle_pct = 49;
    foreach (directed[i])
      send_req(directed[i].kind, directed[i].data, directed[i].fixed, directed[i].rsp);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 49;
          write_regs(8'hA5, 16'd3, 6'd12);
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 21;
          write_regs(8'hFF, 16'hFFFF, 6'd62);
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_regs(8'h00, 16'd0, 6'd0);
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_regs(8'h5A, 16'd20, 6'd5);
        end
      endcase
      run_random(31);
      // The sender holds off here until the ring output has caught up.
      wait_drained();
      run_random(29);
      wait_drained();
    end

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("delimited_frame_receiver_queue_top_test: PASS");
    end else begin
      $display("delimited_frame_receiver_queue_top_test: FAIL");
    end
    $finish;
  end

endmodule
